// ----- sv/mtt_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtt_pkg
// Shared constants, codes and types of the multi-timer table.
// ----------------------------------------------------------------------------
package mtt_pkg;

  // Table size and derived index widths
  localparam int NUM_TIMERS = 16;
  localparam int IDX_W      = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int CNT_W      = IDX_W + 1;

  // Field widths
  localparam int FUNC_W   = 2;
  localparam int SLOT_W   = 4;
  localparam int PERIOD_W = 32;
  localparam int TIME_W   = 48;
  localparam int ENTRY_W  = PERIOD_W + TIME_W;

  // Function codes
  localparam logic [FUNC_W-1:0] FUNC_SET  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_KILL = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_TICK = 2'd2;

  typedef struct packed {
    logic [FUNC_W-1:0]   func;
    logic [SLOT_W-1:0]   timer_slot;
    logic [PERIOD_W-1:0] period_ms;
    logic [TIME_W-1:0]   now_ms;
  } item_t;

  typedef struct packed {
    logic [SLOT_W-1:0] fired_slot;
    logic              fired;
    logic              last;
  } result_t;

  // One timer table entry
  typedef struct packed {
    logic [PERIOD_W-1:0] period;
    logic [TIME_W-1:0]   last_fire;
  } entry_t;

  // Result push request from the sequencer to the output register
  typedef struct packed {
    logic    push;
    result_t data;
  } res_req_t;

  // Table write and read requests
  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    entry_t           data;
  } ram_wr_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
  } ram_rd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FLUSH
  } state_t;

endpackage

// ----- sv/mtt_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtt_item_if / mtt_result_if
// Valid/ready channels for command items and fired-timer results.
// ----------------------------------------------------------------------------
interface mtt_item_if import mtt_pkg::*; ();
  logic  valid;
  logic  ready;
  item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface mtt_result_if import mtt_pkg::*; ();
  logic    valid;
  logic    ready;
  result_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- sv/multi_timer_table_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_timer_table_unit
// Periodic timer table: set, kill and tick commands over 16 slots.
// ----------------------------------------------------------------------------
// Set and kill commands produce no result. A tick walks the table one slot
// per cycle through the entry RAM's single read port, pausing while a new
// fire meets a held slot and a busy output register. The accept step issues
// the first read, each slot is then evaluated in turn, a closing step ends
// the scan and a flush step waits for a free output register. Each tick
// emits one result per fired slot in ascending slot order, the final one
// marked last, or one empty result marked last when nothing fired. The
// block takes the next command once the last result of a tick sits in the
// output register. The valid bits clear at reset; period and time of a
// slot are only meaningful after a set.
// ----------------------------------------------------------------------------
module multi_timer_table_unit import mtt_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  mtt_item_if.sink      item,
  mtt_result_if.source  result
);

  res_req_t            req;
  ram_wr_t             wr;
  ram_rd_t             rd;
  logic [ENTRY_W-1:0]  rd_data;
  logic                out_free;
  logic                res_vld;
  result_t             res_q;

  mtt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .item     (item),
    .out_free (out_free),
    .req      (req),
    .wr       (wr),
    .rd       (rd),
    .rd_data  (rd_data)
  );

  mtt_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (NUM_TIMERS)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr.en),
    .wr_addr (wr.addr),
    .wr_data (ENTRY_W'(wr.data)),
    .rd_en   (rd.en),
    .rd_addr (rd.addr),
    .rd_data (rd_data)
  );

  // Output register: free when empty or being taken
  assign out_free = !res_vld || result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_vld <= 1'b0;
    end else if (req.push) begin
      res_vld <= 1'b1;
    end else if (result.ready) begin
      res_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req.push) begin
      res_q <= req.data;
    end
  end

  assign result.valid = res_vld;
  assign result.data  = res_q;

endmodule

// ----- sv/mtt_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtt_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data. Read data holds while the read enable is low.
// ----------------------------------------------------------------------------
module mtt_ram #(
  parameter int WIDTH = 80,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                       wr_data,
  input  logic                                   rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                       rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- sv/mtt_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtt_ctrl
// Command decoder and tick scan sequencer. Holds the slot valid bits,
// reads each table entry in turn, checks expiry and writes back the new
// last fire time. One fired slot is held back so the final one of a tick
// can be marked last.
// ----------------------------------------------------------------------------
module mtt_ctrl import mtt_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  mtt_item_if.sink         item,
  input  logic             out_free,
  output res_req_t         req,
  output ram_wr_t          wr,
  output ram_rd_t          rd,
  input  logic [ENTRY_W-1:0] rd_data
);

  state_t                  state, state_next;
  logic [NUM_TIMERS-1:0]   valid, valid_next;
  logic [CNT_W-1:0]        rd_idx, rd_idx_next;
  logic                    eval_vld, eval_vld_next;
  logic [IDX_W-1:0]        eval_idx, eval_idx_next;
  logic [TIME_W-1:0]       now_q, now_next;
  logic                    pend_vld, pend_vld_next;
  logic [IDX_W-1:0]        pend_idx, pend_idx_next;

  entry_t                  ent;
  logic [TIME_W:0]         diff;
  logic                    hit;
  logic                    stall;
  logic                    rd_more;
  logic                    in_range;
  logic [IDX_W-1:0]        cmd_idx;

  // Expiry check on the entry held in the registered read data
  always_comb begin
    ent      = entry_t'(rd_data);
    diff     = {1'b0, now_q} - {1'b0, ent.last_fire};
    hit      = eval_vld && valid[eval_idx] && !diff[TIME_W] &&
               (diff[TIME_W-1:0] != '0) &&
               (diff[TIME_W-1:0] >= {{(TIME_W-PERIOD_W){1'b0}}, ent.period});
    stall    = hit && pend_vld && !out_free;
    rd_more  = rd_idx < CNT_W'(NUM_TIMERS);
    in_range = 32'(item.data.timer_slot) < NUM_TIMERS;
    cmd_idx  = IDX_W'(item.data.timer_slot);
  end

  // Next state and outputs
  always_comb begin
    state_next    = state;
    valid_next    = valid;
    rd_idx_next   = rd_idx;
    eval_vld_next = eval_vld;
    eval_idx_next = eval_idx;
    now_next      = now_q;
    pend_vld_next = pend_vld;
    pend_idx_next = pend_idx;
    item.ready    = 1'b0;
    req           = '0;
    wr            = '0;
    rd            = '0;

    unique case (state)
      ST_IDLE: begin
        item.ready = 1'b1;
        if (item.valid) begin
          case (item.data.func)
            FUNC_SET: begin
              if (in_range) begin
                valid_next[cmd_idx]   = 1'b1;
                wr.en                 = 1'b1;
                wr.addr               = cmd_idx;
                wr.data.period        = item.data.period_ms;
                wr.data.last_fire     = item.data.now_ms;
              end
            end
            FUNC_KILL: begin
              if (in_range) begin
                valid_next[cmd_idx] = 1'b0;
              end
            end
            FUNC_TICK: begin
              // Start the scan with a read of slot zero
              now_next      = item.data.now_ms;
              rd.en         = 1'b1;
              rd.addr       = '0;
              eval_vld_next = 1'b1;
              eval_idx_next = '0;
              rd_idx_next   = CNT_W'(1);
              pend_vld_next = 1'b0;
              state_next    = ST_SCAN;
            end
            default: begin
            end
          endcase
        end
      end

      ST_SCAN: begin
        if (!stall) begin
          // Fire: update last fire time, release the previously held slot
          if (hit) begin
            wr.en             = 1'b1;
            wr.addr           = eval_idx;
            wr.data.period    = ent.period;
            wr.data.last_fire = now_q;
            pend_idx_next     = eval_idx;
            pend_vld_next     = 1'b1;
            if (pend_vld) begin
              req.push            = 1'b1;
              req.data.fired_slot = SLOT_W'(pend_idx);
              req.data.fired      = 1'b1;
              req.data.last       = 1'b0;
            end
          end
          // Advance the read pointer
          if (rd_more) begin
            rd.en         = 1'b1;
            rd.addr       = rd_idx[IDX_W-1:0];
            eval_vld_next = 1'b1;
            eval_idx_next = rd_idx[IDX_W-1:0];
            rd_idx_next   = rd_idx + CNT_W'(1);
          end else begin
            eval_vld_next = 1'b0;
            if (!eval_vld) begin
              state_next = ST_FLUSH;
            end
          end
        end
      end

      ST_FLUSH: begin
        // Emit the held slot as last, or an empty result
        if (out_free) begin
          req.push            = 1'b1;
          req.data.fired_slot = pend_vld ? SLOT_W'(pend_idx) : '0;
          req.data.fired      = pend_vld;
          req.data.last       = 1'b1;
          pend_vld_next       = 1'b0;
          state_next          = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      valid    <= '0;
      eval_vld <= 1'b0;
      pend_vld <= 1'b0;
    end else begin
      state    <= state_next;
      valid    <= valid_next;
      eval_vld <= eval_vld_next;
      pend_vld <= pend_vld_next;
    end
  end

  // Scan payload registers
  always_ff @(posedge clk) begin
    rd_idx   <= rd_idx_next;
    eval_idx <= eval_idx_next;
    now_q    <= now_next;
    pend_idx <= pend_idx_next;
  end

endmodule

// ----- verif/mtt_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtt_checker
// Watches the command and result channels of the multi-timer table and
// keeps its own copy of the timer table. Each accepted command updates that
// copy. Each tick command yields the fired-slot results that are due, which
// are queued. Each accepted result is compared field by field with the
// oldest queued one. The mismatch count and the number of results still
// due go to the testbench top.
// ----------------------------------------------------------------------------
module mtt_checker import mtt_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  mtt_item_if         cmd_mon,
  mtt_result_if       fire_mon,
  output int unsigned fire_errors,
  output int unsigned fires_pending,
  output int unsigned fires_checked
);

  // Shadow timer table
  logic                armed      [NUM_TIMERS];
  logic [PERIOD_W-1:0] period_tab [NUM_TIMERS];
  logic [TIME_W-1:0]   fired_at   [NUM_TIMERS];

  // Results due from the block, oldest first
  result_t due_fires[$];

  // Apply one command to the shadow table and queue the results it causes
  function automatic void run_timer_cmd(input item_t cmd);
    result_t             prev;
    bit                  have_prev;
    logic [TIME_W-1:0]   elapsed;
    have_prev = 1'b0;
    prev      = '0;
    case (cmd.func)
      FUNC_SET: begin
        if (int'(cmd.timer_slot) < NUM_TIMERS) begin
          armed[cmd.timer_slot]      = 1'b1;
          period_tab[cmd.timer_slot] = cmd.period_ms;
          fired_at[cmd.timer_slot]   = cmd.now_ms;
        end
      end
      FUNC_KILL: begin
        if (int'(cmd.timer_slot) < NUM_TIMERS) begin
          armed[cmd.timer_slot] = 1'b0;
        end
      end
      FUNC_TICK: begin
        for (int i = 0; i < NUM_TIMERS; i++) begin
          if (armed[i] && cmd.now_ms > fired_at[i]) begin
            elapsed = cmd.now_ms - fired_at[i];
            if (elapsed >= TIME_W'(period_tab[i])) begin
              fired_at[i] = cmd.now_ms;
              if (have_prev) begin
                due_fires.push_back(prev);
              end
              prev.fired_slot = SLOT_W'(i);
              prev.fired      = 1'b1;
              prev.last       = 1'b0;
              have_prev       = 1'b1;
            end
          end
        end
        // Mark the final result; an empty tick still answers once
        prev.last = 1'b1;
        due_fires.push_back(prev);
      end
      default: ;
    endcase
  endfunction

  // Compare results, then record new commands
  always @(posedge clk) begin
    result_t want;
    result_t got;
    if (rst) begin
      for (int i = 0; i < NUM_TIMERS; i++) begin
        armed[i] = 1'b0;
      end
      due_fires.delete();
      fire_errors   = 0;
      fires_checked = 0;
    end else begin
      if (fire_mon.valid && fire_mon.ready) begin
        got = fire_mon.data;
        fires_checked++;
        if (due_fires.size() == 0) begin
          if (fire_errors < 10) begin
            $display("%0t: unexpected result slot %0d fired %0b last %0b",
                     $time, got.fired_slot, got.fired, got.last);
          end
          fire_errors++;
        end else begin
          want = due_fires.pop_front();
          if (got.fired_slot !== want.fired_slot || got.fired !== want.fired ||
              got.last !== want.last) begin
            if (fire_errors < 10) begin
              $display("%0t: result mismatch, expected slot %0d fired %0b last %0b,",
                       $time, want.fired_slot, want.fired, want.last);
              $display("         got slot %0d fired %0b last %0b",
                       got.fired_slot, got.fired, got.last);
            end
            fire_errors++;
          end
        end
      end
      if (cmd_mon.valid && cmd_mon.ready) begin
        run_timer_cmd(cmd_mon.data);
      end
    end
    fires_pending = due_fires.size();
  end

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Top of the multi-timer table testbench. Drives set, kill, tick and unused
// commands into the block: first a directed pass over the time and period
// extremes, then random timer traffic with a mostly advancing clock. Both
// channels idle at random; the result side holds off once for a long
// stretch and the command side drains the block after the directed pass
// and mid-run. A checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb;
  import mtt_pkg::*;

  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS = 290;
  localparam int LONG_HOLD    = 300;
  localparam int DRAIN_CYCLES = 40;
  localparam int CYCLE_LIMIT  = 2_000_000;

  logic clk;
  logic rst;

  mtt_item_if   cmd_ch();
  mtt_result_if fire_ch();

  int unsigned fire_errors;
  int unsigned fires_pending;
  int unsigned fires_checked;

  int unsigned cycles;
  bit          hold_req;
  bit          steady;
  int          n_set;
  int          n_kill;
  int          n_tick;
  int          n_unused;

  multi_timer_table_unit dut (
    .clk    (clk),
    .rst    (rst),
    .item   (cmd_ch),
    .result (fire_ch)
  );

  mtt_checker chk (
    .clk           (clk),
    .rst           (rst),
    .cmd_mon       (cmd_ch),
    .fire_mon      (fire_ch),
    .fire_errors   (fire_errors),
    .fires_pending (fires_pending),
    .fires_checked (fires_checked)
  );

  // 100 MHz clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Abort a hung run
  initial cycles = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("== FAIL ==");
      $finish;
    end
  end

  // Idle length: mostly none or short, now and then long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 93) return $urandom_range(1, 4);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [TIME_W-1:0] any_time();
    return {16'($urandom_range(0, 65535)), 32'($urandom)};
  endfunction

  function automatic logic [PERIOD_W-1:0] pick_period();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return PERIOD_W'($urandom_range(0, 8));
    if (r < 85) return PERIOD_W'($urandom_range(9, 100));
    if (r < 95) return PERIOD_W'($urandom);
    return (r[0]) ? '1 : '0;
  endfunction

  // Offer one command, wait for the transaction, then maybe idle.
  // Called and returns at a falling edge.
  task automatic issue(input logic [FUNC_W-1:0] f, input logic [SLOT_W-1:0] s,
                       input logic [PERIOD_W-1:0] p, input logic [TIME_W-1:0] t);
    item_t it;
    int    gap;
    it.func       = f;
    it.timer_slot = s;
    it.period_ms  = p;
    it.now_ms     = t;
    cmd_ch.data  <= it;
    cmd_ch.valid <= 1'b1;
    @(posedge clk);
    while (!cmd_ch.ready) @(posedge clk);
    @(negedge clk);
    case (f)
      FUNC_SET:  n_set++;
      FUNC_KILL: n_kill++;
      FUNC_TICK: n_tick++;
      default:   n_unused++;
    endcase
    gap = steady ? 0 : pick_gap();
    if (gap > 0) begin
      cmd_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  // Stop offering until every due result has come out
  task automatic drain();
    cmd_ch.valid <= 1'b0;
    @(negedge clk);
    while (fires_pending != 0) @(negedge clk);
  endtask

  // Result side: bursts of ready, random stalls, one long hold-off
  initial begin
    bit hold_served;
    int gap;
    hold_served   = 1'b0;
    fire_ch.ready = 1'b0;
    wait (rst == 1'b0);
    @(negedge clk);
    forever begin
      if (hold_req && !hold_served) begin
        hold_served = 1'b1;
        fire_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
      end else begin
        fire_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 24)) @(negedge clk);
        gap = pick_gap();
        if (gap > 0) begin
          fire_ch.ready <= 1'b0;
          repeat (gap) @(negedge clk);
        end
      end
    end
  end

  // Command stimulus and verdict
  initial begin
    logic [TIME_W-1:0] clock_ms;
    int                sent;
    int                pick;
    bit                paused;
    rst          = 1'b1;
    cmd_ch.valid = 1'b0;
    cmd_ch.data  = '0;
    hold_req     = 1'b0;
    steady       = 1'b0;
    paused       = 1'b0;
    n_set        = 0;
    n_kill       = 0;
    n_tick       = 0;
    n_unused     = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: empty table, equal times, time and period extremes
    issue(FUNC_TICK, 4'd0, '0, '0);
    issue(FUNC_SET, 4'd0, '0, '0);
    issue(FUNC_TICK, 4'd0, '0, '0);       // now equals last fire: no fire at period 0
    issue(FUNC_TICK, 4'd0, '0, 48'd1);
    issue(FUNC_SET, 4'd15, '1, 48'd1);
    issue(FUNC_TICK, 4'd0, '0, 48'd2);
    issue(FUNC_KILL, 4'd7, '1, '1);        // idle slot
    issue(FUNC_UNUSED, 4'd9, '1, '1);
    issue(FUNC_SET, 4'd15, '1, '0);
    issue(FUNC_TICK, 4'd0, '0, '1);        // full span beats the largest period
    issue(FUNC_SET, 4'd5, 32'd10, 48'hFFFF_FFFF_FFF0);
    issue(FUNC_TICK, 4'd0, '0, '1);
    issue(FUNC_TICK, 4'd0, '0, 48'd100);   // time runs backwards
    issue(FUNC_SET, 4'd10, 32'h8000_0000, 48'h8000_0000_0000);
    issue(FUNC_TICK, 4'd0, '0, 48'h8000_7FFF_FFFF);
    issue(FUNC_TICK, 4'd0, '0, 48'h8000_8000_0000);
    issue(FUNC_KILL, 4'd0, '0, '0);
    issue(FUNC_KILL, 4'd0, '0, '0);
    issue(FUNC_KILL, 4'd5, '0, '0);
    issue(FUNC_KILL, 4'd15, '0, '0);
    issue(FUNC_TICK, 4'd0, '0, 48'h8000_9000_0000);
    drain();

    // Random timer traffic on a mostly advancing clock
    clock_ms = 48'd1000;
    sent     = 0;
    while (sent < RANDOM_ITEMS) begin
      if (sent % 40 == 0) steady = ($urandom_range(0, 2) == 0);
      if (sent >= 100) hold_req = 1'b1;
      if (sent >= 200 && !paused) begin
        paused = 1'b1;
        drain();
      end
      pick = $urandom_range(0, 99);
      if (pick < 3) begin
        // Arm every slot with a short period, then fire them all at once
        for (int s = 0; s < NUM_TIMERS; s++) begin
          issue(FUNC_SET, SLOT_W'(s), PERIOD_W'($urandom_range(0, 3)), clock_ms);
        end
        clock_ms += TIME_W'($urandom_range(4, 10));
        issue(FUNC_TICK, SLOT_W'($urandom), PERIOD_W'($urandom), clock_ms);
        sent += NUM_TIMERS + 1;
      end else if (pick < 38) begin
        issue(FUNC_SET, SLOT_W'($urandom), pick_period(), clock_ms);
        sent++;
      end else if (pick < 48) begin
        issue(FUNC_KILL, SLOT_W'($urandom), PERIOD_W'($urandom), any_time());
        sent++;
      end else if (pick < 90) begin
        pick = $urandom_range(0, 99);
        if (pick < 4) clock_ms = any_time();
        else if (pick < 8) clock_ms -= TIME_W'($urandom_range(1, 20));
        else clock_ms += TIME_W'($urandom_range(0, 6));
        issue(FUNC_TICK, SLOT_W'($urandom), PERIOD_W'($urandom), clock_ms);
        sent++;
      end else if (pick < 95) begin
        issue(FUNC_UNUSED, SLOT_W'($urandom), PERIOD_W'($urandom), any_time());
      end else begin
        // Noise: commands at arbitrary times
        issue(pick[0] ? FUNC_TICK : FUNC_SET, SLOT_W'($urandom), PERIOD_W'($urandom),
              any_time());
        sent++;
      end
    end

    // Let the block finish and settle
    cmd_ch.valid <= 1'b0;
    @(negedge clk);
    while (fires_pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Covered %0d set, %0d kill, %0d tick and %0d unused-code transactions,",
             n_set, n_kill, n_tick, n_unused);
    $display("with %0d timer results checked in %0d cycles.", fires_checked, cycles);
    if (fire_errors == 0 && fires_pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ----- files.f -----
sv/mtt_pkg.sv
sv/mtt_if.sv
sv/mtt_ram.sv
sv/mtt_ctrl.sv
sv/multi_timer_table_unit.sv
verif/mtt_checker.sv
verif/tb.sv
